/* rtl/adsr_pkg.sv */
package adsr_pkg;

    localparam int HOLD_BITS_DEFAULT = 24;

    localparam int COEF_W   = 17;
    localparam int ATGT_W   = 20;
    localparam int HTICK_W  = 24;
    localparam int LEVEL_W  = 18;
    localparam int CALC_W   = 22;
    localparam int MAG_W    = 21;
    localparam int PROD_W   = COEF_W + MAG_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [COEF_W-1:0]         Q_ONE_COEF  = COEF_W'(65536);
    localparam logic [ATGT_W-1:0]         Q_ONE_TGT   = ATGT_W'(65536);
    localparam logic [COEF_W-1:0]         FAST_COEF   = COEF_W'(32768);
    localparam logic signed [LEVEL_W-1:0] REL_TARGET  = -LEVEL_W'(6554);
    localparam logic signed [LEVEL_W-1:0] Q_ONE_LEVEL = LEVEL_W'(65536);
    localparam logic signed [CALC_W-1:0]  Q_ONE_CALC  = CALC_W'(65536);
    localparam logic [PROD_W-1:0]         ROUND_UP    = PROD_W'(65535);

    localparam logic [COEF_W-1:0]  RST_ATTACK_COEF   = COEF_W'(65536);
    localparam logic [ATGT_W-1:0]  RST_ATTACK_TARGET = ATGT_W'(65536);
    localparam logic [COEF_W-1:0]  RST_DECAY_COEF    = COEF_W'(65536);
    localparam logic [COEF_W-1:0]  RST_RELEASE_COEF  = COEF_W'(65536);
    localparam logic [COEF_W-1:0]  RST_SUSTAIN_LEVEL = COEF_W'(45875);
    localparam logic [HTICK_W-1:0] RST_HOLD_TICKS    = '0;

    typedef enum logic [2:0] {
        SEG_IDLE    = 3'd0,
        SEG_ATTACK  = 3'd1,
        SEG_HOLD    = 3'd2,
        SEG_DECAY   = 3'd3,
        SEG_RELEASE = 3'd4
    } seg_t;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_GATE_ON  = 2'd1,
        FUNC_GATE_OFF = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        HARD_NOW    = 2'd0,
        HARD_FAST   = 2'd1,
        HARD_NORMAL = 2'd2,
        HARD_ALT    = 2'd3
    } hard_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ATTACK_COEF   = 3'd0,
        CFG_ATTACK_TARGET = 3'd1,
        CFG_DECAY_COEF    = 3'd2,
        CFG_RELEASE_COEF  = 3'd3,
        CFG_SUSTAIN_LEVEL = 3'd4,
        CFG_HOLD_TICKS    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] hardness;
    } req_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [2:0]                segment;
        logic                      active;
    } rsp_t;

    function automatic logic [COEF_W-1:0] clamp_one(input logic [COEF_W-1:0] v);
        return (v > Q_ONE_COEF) ? Q_ONE_COEF : v;
    endfunction

    function automatic logic [ATGT_W-1:0] floor_one(input logic [ATGT_W-1:0] v);
        return (v < Q_ONE_TGT) ? Q_ONE_TGT : v;
    endfunction

endpackage

/* rtl/adsr_envelope_generator.sv */
// Exponential ADSR envelope generator, Q16 (1.0 = 65536). One beat in on req
// gives one beat out on rsp; a new beat is taken every clock while req_ready is
// high, and its result is registered into the output buffer. The figure of one
// beat per cycle is set by the single multiply-accumulate path (17 x 21 bit
// coefficient product, round-up, add and compare) between the segment state
// and the result register. A two-entry output buffer keeps req_ready high while
// one result waits on rsp_ready. Configuration writes via cfg_we take effect on
// the next beat; coefficients above 1.0 act as 1.0.
module adsr_envelope_generator #(
    parameter int HOLD_BITS = adsr_pkg::HOLD_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  adsr_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output adsr_pkg::rsp_t                   rsp,
    input  logic                             cfg_we,
    input  logic [adsr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int COEF_W  = adsr_pkg::COEF_W;
    localparam int ATGT_W  = adsr_pkg::ATGT_W;
    localparam int HTICK_W = adsr_pkg::HTICK_W;
    localparam int LEVEL_W = adsr_pkg::LEVEL_W;
    localparam int CALC_W  = adsr_pkg::CALC_W;
    localparam int MAG_W   = adsr_pkg::MAG_W;
    localparam int PROD_W  = adsr_pkg::PROD_W;

    // configuration
    logic [COEF_W-1:0]  attack_coef_reg;
    logic [ATGT_W-1:0]  attack_target_reg;
    logic [COEF_W-1:0]  decay_coef_reg;
    logic [COEF_W-1:0]  release_coef_reg;
    logic [COEF_W-1:0]  sustain_level_reg;
    logic [HTICK_W-1:0] hold_ticks_reg;

    // segment state
    adsr_pkg::seg_t              phase_reg, phase_next;
    logic signed [LEVEL_W-1:0]   env_reg, env_next;
    logic signed [LEVEL_W-1:0]   target_reg, target_next;
    logic [COEF_W-1:0]           coef_reg, coef_next;
    logic [HOLD_BITS-1:0]        hold_left_reg, hold_left_next;

    // output buffer
    logic           out_valid_reg, skid_valid_reg;
    adsr_pkg::rsp_t out_reg, skid_reg;
    adsr_pkg::rsp_t result;
    logic signed [LEVEL_W-1:0] level;

    logic req_fire;

    logic [HOLD_BITS-1:0]       hold_len;
    logic signed [CALC_W-1:0]   pole_x, pole_target, pole_diff, pole_new;
    logic [MAG_W-1:0]           pole_mag, pole_step;
    logic [PROD_W-1:0]          pole_prod, pole_sum;

    assign req_ready = !skid_valid_reg;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign hold_len = HOLD_BITS'(hold_ticks_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_coef_reg   <= adsr_pkg::RST_ATTACK_COEF;
            attack_target_reg <= adsr_pkg::RST_ATTACK_TARGET;
            decay_coef_reg    <= adsr_pkg::RST_DECAY_COEF;
            release_coef_reg  <= adsr_pkg::RST_RELEASE_COEF;
            sustain_level_reg <= adsr_pkg::RST_SUSTAIN_LEVEL;
            hold_ticks_reg    <= adsr_pkg::RST_HOLD_TICKS;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                adsr_pkg::CFG_ATTACK_COEF:   attack_coef_reg   <= cfg_wdata[COEF_W-1:0];
                adsr_pkg::CFG_ATTACK_TARGET: attack_target_reg <= cfg_wdata[ATGT_W-1:0];
                adsr_pkg::CFG_DECAY_COEF:    decay_coef_reg    <= cfg_wdata[COEF_W-1:0];
                adsr_pkg::CFG_RELEASE_COEF:  release_coef_reg  <= cfg_wdata[COEF_W-1:0];
                adsr_pkg::CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_wdata[COEF_W-1:0];
                adsr_pkg::CFG_HOLD_TICKS:    hold_ticks_reg    <= cfg_wdata[HTICK_W-1:0];
                default: ;
            endcase
        end
    end

    // one-pole step, magnitude of the step rounded up
    always_comb
    begin
        pole_x = CALC_W'(env_reg);
        if (phase_reg == adsr_pkg::SEG_ATTACK)
            pole_target = CALC_W'(adsr_pkg::floor_one(attack_target_reg));
        else
            pole_target = CALC_W'(target_reg);
        pole_diff = pole_target - pole_x;
        pole_mag  = pole_diff[CALC_W-1] ? MAG_W'(-pole_diff) : MAG_W'(pole_diff);
        pole_prod = coef_reg * pole_mag;
        pole_sum  = pole_prod + adsr_pkg::ROUND_UP;
        pole_step = pole_sum[MAG_W+15:16];
        if (pole_diff[CALC_W-1])
            pole_new = pole_x - $signed({1'b0, pole_step});
        else
            pole_new = pole_x + $signed({1'b0, pole_step});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= adsr_pkg::SEG_IDLE;
            env_reg       <= '0;
            target_reg    <= '0;
            coef_reg      <= '0;
            hold_left_reg <= '0;
        end
        else if (req_fire)
        begin
            phase_reg     <= phase_next;
            env_reg       <= env_next;
            target_reg    <= target_next;
            coef_reg      <= coef_next;
            hold_left_reg <= hold_left_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        env_next       = env_reg;
        target_next    = target_reg;
        coef_next      = coef_reg;
        hold_left_next = hold_left_reg;
        level          = env_reg;

        case (req.func)
            adsr_pkg::FUNC_TICK:
            begin
                case (phase_reg)
                    adsr_pkg::SEG_IDLE:
                        level = '0;
                    adsr_pkg::SEG_ATTACK:
                    begin
                        env_next = LEVEL_W'(pole_new);
                        if (pole_new >= adsr_pkg::Q_ONE_CALC)
                        begin
                            env_next = adsr_pkg::Q_ONE_LEVEL;
                            if (hold_len != '0)
                            begin
                                phase_next     = adsr_pkg::SEG_HOLD;
                                hold_left_next = hold_len;
                            end
                            else
                            begin
                                phase_next  = adsr_pkg::SEG_DECAY;
                                target_next = LEVEL_W'(adsr_pkg::clamp_one(sustain_level_reg));
                                coef_next   = adsr_pkg::clamp_one(decay_coef_reg);
                            end
                        end
                        level = env_next;
                    end
                    adsr_pkg::SEG_HOLD:
                    begin
                        if (hold_left_reg != '0)
                            hold_left_next = hold_left_reg - HOLD_BITS'(1);
                        else
                        begin
                            phase_next  = adsr_pkg::SEG_DECAY;
                            target_next = LEVEL_W'(adsr_pkg::clamp_one(sustain_level_reg));
                            coef_next   = adsr_pkg::clamp_one(decay_coef_reg);
                        end
                    end
                    adsr_pkg::SEG_DECAY, adsr_pkg::SEG_RELEASE:
                    begin
                        level    = LEVEL_W'(pole_new);
                        env_next = LEVEL_W'(pole_new);
                        if (pole_new <= 0)
                        begin
                            phase_next = adsr_pkg::SEG_IDLE;
                            env_next   = '0;
                        end
                    end
                    default: ;
                endcase
            end
            adsr_pkg::FUNC_GATE_ON:
            begin
                phase_next = adsr_pkg::SEG_ATTACK;
                coef_next  = adsr_pkg::clamp_one(attack_coef_reg);
                if (req.hardness == adsr_pkg::HARD_NOW)
                    env_next = '0;
                level = env_next;
            end
            adsr_pkg::FUNC_GATE_OFF:
            begin
                target_next = adsr_pkg::REL_TARGET;
                case (req.hardness)
                    adsr_pkg::HARD_NOW:
                    begin
                        phase_next = adsr_pkg::SEG_IDLE;
                        env_next   = '0;
                    end
                    adsr_pkg::HARD_FAST:
                    begin
                        phase_next = adsr_pkg::SEG_RELEASE;
                        coef_next  = adsr_pkg::FAST_COEF;
                    end
                    default:
                    begin
                        phase_next = adsr_pkg::SEG_RELEASE;
                        coef_next  = adsr_pkg::clamp_one(release_coef_reg);
                    end
                endcase
                level = env_next;
            end
            default: ;
        endcase

        result.level   = level;
        result.segment = phase_next;
        result.active  = (phase_next != adsr_pkg::SEG_IDLE);
    end

    // two-entry result buffer; a beat lands in skid only while rsp is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= req_fire;
        end
        else if (req_fire)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || rsp_ready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (req_fire)
                out_reg <= result;
        end
        else if (req_fire)
            skid_reg <= result;
    end

endmodule

/* dv/adsr_envelope_generator_checker.sv */
`timescale 1ns / 1ps

module adsr_envelope_generator_checker
    import adsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  req_t                  req,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    pending
);

    localparam int MAX_PRINTS = 50;

    logic [COEF_W-1:0]  cf_attack_coef;
    logic [ATGT_W-1:0]  cf_attack_target;
    logic [COEF_W-1:0]  cf_decay_coef;
    logic [COEF_W-1:0]  cf_release_coef;
    logic [COEF_W-1:0]  cf_sustain;
    logic [HTICK_W-1:0] cf_hold_ticks;

    seg_t                      env_seg;
    logic signed [CALC_W-1:0]  env_level;
    logic signed [CALC_W-1:0]  env_aim;
    logic [COEF_W-1:0]         env_rate;
    logic [HTICK_W-1:0]        hold_count;

    rsp_t expected_env[$];

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: envelope mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [COEF_W-1:0] unit_cap(input logic [COEF_W-1:0] v);
        return (v > Q_ONE_COEF) ? Q_ONE_COEF : v;
    endfunction

    // one-pole step, magnitude of the increment rounded up
    function automatic logic signed [CALC_W-1:0] glide(
        input logic signed [CALC_W-1:0] x,
        input logic signed [CALC_W-1:0] aim,
        input logic [COEF_W-1:0]        rate
    );
        longint gap;
        longint mag;
        longint stepsz;
        gap    = longint'(aim) - longint'(x);
        mag    = (gap < 0) ? -gap : gap;
        stepsz = (longint'(rate) * mag + 65535) >>> 16;
        return CALC_W'((gap < 0) ? longint'(x) - stepsz : longint'(x) + stepsz);
    endfunction

    function automatic void enter_decay();
        env_seg  = SEG_DECAY;
        env_aim  = CALC_W'(unit_cap(cf_sustain));
        env_rate = unit_cap(cf_decay_coef);
    endfunction

    function automatic rsp_t predict_envelope(input req_t beat);
        rsp_t                     res;
        logic signed [CALC_W-1:0] shown;
        logic [ATGT_W-1:0]        peak;
        shown = env_level;
        case (func_t'(beat.func))
            FUNC_TICK:
            begin
                case (env_seg)
                    SEG_IDLE:
                    begin
                        shown = '0;
                    end
                    SEG_ATTACK:
                    begin
                        peak = (cf_attack_target < Q_ONE_TGT) ? Q_ONE_TGT : cf_attack_target;
                        env_level = glide(env_level, CALC_W'(peak), env_rate);
                        if (env_level >= Q_ONE_CALC)
                        begin
                            env_level = Q_ONE_CALC;
                            if (cf_hold_ticks != '0)
                            begin
                                env_seg    = SEG_HOLD;
                                hold_count = cf_hold_ticks;
                            end
                            else
                            begin
                                enter_decay();
                            end
                        end
                        shown = env_level;
                    end
                    SEG_HOLD:
                    begin
                        shown = env_level;
                        if (hold_count != '0)
                            hold_count = hold_count - 1'b1;
                        else
                            enter_decay();
                    end
                    default:
                    begin
                        env_level = glide(env_level, env_aim, env_rate);
                        shown = env_level;
                        if (env_level <= 0)
                        begin
                            env_seg   = SEG_IDLE;
                            env_level = '0;
                        end
                    end
                endcase
            end
            FUNC_GATE_ON:
            begin
                env_seg  = SEG_ATTACK;
                env_rate = unit_cap(cf_attack_coef);
                if (beat.hardness == HARD_NOW)
                    env_level = '0;
                shown = env_level;
            end
            FUNC_GATE_OFF:
            begin
                env_aim = REL_TARGET;
                case (hard_t'(beat.hardness))
                    HARD_NOW:
                    begin
                        env_seg   = SEG_IDLE;
                        env_level = '0;
                    end
                    HARD_FAST:
                    begin
                        env_seg  = SEG_RELEASE;
                        env_rate = FAST_COEF;
                    end
                    default:
                    begin
                        env_seg  = SEG_RELEASE;
                        env_rate = unit_cap(cf_release_coef);
                    end
                endcase
                shown = env_level;
            end
            default:
            begin
            end
        endcase
        res.level   = shown[LEVEL_W-1:0];
        res.segment = env_seg;
        res.active  = (env_seg != SEG_IDLE);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            cf_attack_coef   = RST_ATTACK_COEF;
            cf_attack_target = RST_ATTACK_TARGET;
            cf_decay_coef    = RST_DECAY_COEF;
            cf_release_coef  = RST_RELEASE_COEF;
            cf_sustain       = RST_SUSTAIN_LEVEL;
            cf_hold_ticks    = RST_HOLD_TICKS;
            env_seg          = SEG_IDLE;
            env_level        = '0;
            env_aim          = '0;
            env_rate         = '0;
            hold_count       = '0;
            mismatches       = 0;
            expected_env.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_ATTACK_COEF:   cf_attack_coef   = cfg_wdata[COEF_W-1:0];
                    CFG_ATTACK_TARGET: cf_attack_target = cfg_wdata[ATGT_W-1:0];
                    CFG_DECAY_COEF:    cf_decay_coef    = cfg_wdata[COEF_W-1:0];
                    CFG_RELEASE_COEF:  cf_release_coef  = cfg_wdata[COEF_W-1:0];
                    CFG_SUSTAIN_LEVEL: cf_sustain       = cfg_wdata[COEF_W-1:0];
                    CFG_HOLD_TICKS:    cf_hold_ticks    = cfg_wdata[HTICK_W-1:0];
                    default:           ;
                endcase
            end
            if (req_valid && req_ready)
                expected_env.push_back(predict_envelope(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_env.size() == 0)
                begin
                    report_mismatch("result beat with nothing outstanding");
                end
                else
                begin
                    want = expected_env.pop_front();
                    if (rsp.level !== want.level)
                        report_mismatch($sformatf("level %0d, want %0d",
                                                  rsp.level, want.level));
                    if (rsp.segment !== want.segment)
                        report_mismatch($sformatf("segment %0d, want %0d",
                                                  rsp.segment, want.segment));
                    if (rsp.active !== want.active)
                        report_mismatch($sformatf("active %0b, want %0b",
                                                  rsp.active, want.active));
                end
            end
            pending <= expected_env.size();
        end
    end

endmodule

/* dv/adsr_envelope_generator_tb.sv */
`timescale 1ns / 1ps

module adsr_envelope_generator_tb;

    import adsr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 10;
    localparam int PHASE_BEATS    = 200;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int send_idle_pct;
    int stall_pct;
    int mismatches;
    int pending;
    int quiet_cycles;

    always #6 clk = ~clk;

    adsr_envelope_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    adsr_envelope_generator_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_beat(input func_t f, input hard_t h);
        req_t beat;
        beat.func     = f;
        beat.hardness = h;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int width,
                             input logic [CFG_DATA_W-1:0] data);
        logic [CFG_DATA_W-1:0] keep;
        keep = (width >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << width) - 1'b1);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= (data & keep) | (CFG_DATA_W'($urandom) & ~keep);
        @(posedge clk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        if ($urandom_range(9) == 0)
            return COEF_W'($urandom_range(0, 131071));
        return COEF_W'($urandom_range(2000, 65536));
    endfunction

    task automatic program_envelope(input int kind);
        logic [COEF_W-1:0]  ac;
        logic [COEF_W-1:0]  dc;
        logic [COEF_W-1:0]  rc;
        logic [COEF_W-1:0]  sl;
        logic [ATGT_W-1:0]  at;
        logic [HTICK_W-1:0] ht;
        case (kind)
            0:
            begin
                ac = '1; dc = '1; rc = '1; sl = '1; at = '1; ht = '0;
            end
            1:
            begin
                ac = Q_ONE_COEF; dc = '0; rc = '0; sl = '0; at = '0; ht = '1;
            end
            2:
            begin
                ac = '0; dc = pick_coef(); rc = pick_coef();
                sl = COEF_W'($urandom_range(0, 65536)); at = ATGT_W'($urandom); ht = '0;
            end
            3:
            begin
                ac = Q_ONE_COEF; dc = Q_ONE_COEF; rc = Q_ONE_COEF;
                sl = Q_ONE_COEF; at = Q_ONE_TGT; ht = HTICK_W'(1);
            end
            default:
            begin
                ac = pick_coef();
                dc = pick_coef();
                rc = pick_coef();
                sl = ($urandom_range(9) == 0) ? COEF_W'($urandom)
                                              : COEF_W'($urandom_range(0, 65536));
                at = ($urandom_range(1) == 0) ? ATGT_W'($urandom)
                                              : ATGT_W'($urandom_range(65536, 200000));
                ht = ($urandom_range(9) == 0) ? HTICK_W'($urandom)
                                              : HTICK_W'($urandom_range(0, 12));
            end
        endcase
        write_reg(CFG_ATTACK_COEF, COEF_W, CFG_DATA_W'(ac));
        write_reg(CFG_ATTACK_TARGET, ATGT_W, CFG_DATA_W'(at));
        write_reg(CFG_DECAY_COEF, COEF_W, CFG_DATA_W'(dc));
        write_reg(CFG_RELEASE_COEF, COEF_W, CFG_DATA_W'(rc));
        write_reg(CFG_SUSTAIN_LEVEL, COEF_W, CFG_DATA_W'(sl));
        write_reg(CFG_HOLD_TICKS, HTICK_W, CFG_DATA_W'(ht));
        write_reg(CFG_SPARE_LO, CFG_DATA_W, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DATA_W, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly whole notes: gate on, some ticks, gate off, tail of ticks
    task automatic play_notes(input int n);
        int sent;
        int held;
        int tail;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < 75)
            begin
                held = $urandom_range(1, 40);
                tail = $urandom_range(0, 30);
                send_beat(FUNC_GATE_ON, hard_t'($urandom_range(3)));
                repeat (held)
                    send_beat(FUNC_TICK, hard_t'($urandom_range(3)));
                send_beat(FUNC_GATE_OFF, hard_t'($urandom_range(3)));
                repeat (tail)
                    send_beat(FUNC_TICK, hard_t'($urandom_range(3)));
                sent += held + tail + 2;
            end
            else
            begin
                send_beat(func_t'($urandom_range(3)), hard_t'($urandom_range(3)));
                sent++;
            end
        end
    endtask

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("adsr_envelope_generator_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: instant attack, no hold, decay to sustain, release past zero
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_NONE, HARD_ALT);
        send_beat(FUNC_GATE_ON, HARD_NOW);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_TICK, HARD_FAST);
        send_beat(FUNC_NONE, HARD_NORMAL);
        send_beat(FUNC_GATE_OFF, HARD_NORMAL);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_GATE_ON, HARD_ALT);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_GATE_OFF, HARD_FAST);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_GATE_ON, HARD_FAST);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_GATE_OFF, HARD_ALT);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_GATE_ON, HARD_NORMAL);
        send_beat(FUNC_TICK, HARD_NOW);
        send_beat(FUNC_GATE_OFF, HARD_NOW);
        send_beat(FUNC_NONE, HARD_NOW);
        send_beat(FUNC_TICK, HARD_NOW);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            repeat (2)
                @(posedge clk);
            program_envelope(phase);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 45; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            play_notes(PHASE_BEATS);
        end

        drain();
        repeat (8)
            @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("adsr_envelope_generator_tb: PASS");
        else
            $display("adsr_envelope_generator_tb: FAIL");
        $finish;
    end

endmodule
